// ----- hdl/prrq_pkg.sv -----
// shared types and codes for the per-user priority round-robin queue
// no dependencies
`default_nettype none
package prrq_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SERVE  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNKNOWN    = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_QUEUE_FULL = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_ADD,
    S_SRD,
    S_SPOP,
    S_DROP,
    S_FIN
  } state_e;

endpackage
`default_nettype wire

// ----- hdl/prrq_jobmem.sv -----
// job size store, one write port and one registered read port
// no dependencies
`default_nettype none
module prrq_jobmem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [15:0]   wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [15:0]   rdata_o
);

  logic [15:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hdl/per_user_priority_round_robin_queue.sv -----
// an add scans the order, then writes the job (find, add); a remove scans the order, then
// shifts the user out if found (find, drop); a serve reads memory, pops, then shifts the order
// (srd, spop, drop); an empty serve and an unused action go straight to the result
// one transaction at a time, ready again once the result is loaded;
// a held result stalls the input. async reset empties the order and queues, not job stores
// uses prrq_pkg and prrq_jobmem
`default_nettype none
module per_user_priority_round_robin_queue
  import prrq_pkg::*;
#(
  parameter int MAX_USERS      = 8,
  parameter int JOBS_PER_QUEUE = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] user_id_i,
  input  wire logic [15:0] job_size_i,
  input  wire logic        is_urgent_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [15:0]      served_user_o,
  output logic [15:0]      served_size_o,
  output logic             served_urgent_o,
  output logic             user_requeued_o
);

  localparam int SW    = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int CW    = $clog2(MAX_USERS + 1);
  localparam int HW    = (JOBS_PER_QUEUE > 1) ? $clog2(JOBS_PER_QUEUE) : 1;
  localparam int FW    = $clog2(JOBS_PER_QUEUE + 1);
  localparam int DEPTH = MAX_USERS * JOBS_PER_QUEUE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_e state_q, state_d;

  logic [SW-1:0] order_q [MAX_USERS];
  logic [15:0]   owner_q [MAX_USERS];
  logic [HW-1:0] uhead_q [MAX_USERS];
  logic [HW-1:0] nhead_q [MAX_USERS];
  logic [FW-1:0] ufill_q [MAX_USERS];
  logic [FW-1:0] nfill_q [MAX_USERS];
  logic [MAX_USERS-1:0] used_q;
  logic [CW-1:0] active_q;
  logic [CW-1:0] idx_q;
  logic [SW-1:0] slot_q;
  logic          found_q;
  logic          requeue_q;

  action_e       act_q;
  logic [15:0]   uid_q;
  logic [15:0]   size_q;
  logic          urg_q;

  status_e       res_status_q;
  logic [15:0]   res_user_q;
  logic [15:0]   res_size_q;
  logic          res_urg_q;
  logic          res_req_q;

  logic          out_valid_q;
  logic [2:0]    status_q;
  logic [15:0]   served_user_q;
  logic [15:0]   served_size_q;
  logic          served_urgent_q;
  logic          user_requeued_q;

  // scan and free slot
  logic [SW-1:0] scan_slot;
  logic          scan_hit;
  logic          scan_end;
  logic [SW-1:0] free_slot;
  always_comb begin
    scan_slot = order_q[idx_q[SW-1:0]];
    scan_hit  = (owner_q[scan_slot] == uid_q);
    scan_end  = (idx_q >= active_q);
    free_slot = '0;
    for (int s = MAX_USERS - 1; s >= 0; s--) begin
      if (!used_q[s]) free_slot = SW'(s);
    end
  end

  // add path
  logic [SW-1:0] add_slot;
  logic [HW-1:0] add_head;
  logic [FW-1:0] add_fill;
  logic [FW:0]   add_sum;
  logic [HW-1:0] add_idx;
  logic          add_full;
  always_comb begin
    add_slot = found_q ? slot_q : free_slot;
    add_head = found_q ? (urg_q ? uhead_q[add_slot] : nhead_q[add_slot]) : '0;
    add_fill = found_q ? (urg_q ? ufill_q[add_slot] : nfill_q[add_slot]) : '0;
    add_sum  = (FW + 1)'(add_head) + (FW + 1)'(add_fill);
    if (add_sum >= (FW + 1)'(JOBS_PER_QUEUE)) begin
      add_idx = HW'(add_sum - (FW + 1)'(JOBS_PER_QUEUE));
    end else begin
      add_idx = HW'(add_sum);
    end
    add_full = (add_fill >= FW'(JOBS_PER_QUEUE));
  end

  // memories
  logic          u_we, n_we;
  logic [AW-1:0] waddr, uraddr, nraddr;
  logic [15:0]   urdata, nrdata;
  assign waddr  = AW'(add_slot) * AW'(JOBS_PER_QUEUE) + AW'(add_idx);
  assign uraddr = AW'(slot_q) * AW'(JOBS_PER_QUEUE) + AW'(uhead_q[slot_q]);
  assign nraddr = AW'(slot_q) * AW'(JOBS_PER_QUEUE) + AW'(nhead_q[slot_q]);

  prrq_jobmem #(.DEPTH(DEPTH), .AW(AW)) u_urgent_mem (
    .clk_i, .we_i(u_we), .waddr_i(waddr), .wdata_i(size_q),
    .raddr_i(uraddr), .rdata_o(urdata)
  );
  prrq_jobmem #(.DEPTH(DEPTH), .AW(AW)) u_normal_mem (
    .clk_i, .we_i(n_we), .waddr_i(waddr), .wdata_i(size_q),
    .raddr_i(nraddr), .rdata_o(nrdata)
  );

  logic add_ok;
  logic add_tfull;
  assign add_tfull = !found_q && (active_q >= CW'(MAX_USERS));
  assign add_ok    = !add_tfull && !add_full;

  // fsm outputs
  logic in_acc, out_load;
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    in_acc     = in_valid_i && in_ready_o;
    out_load   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
    u_we       = (state_q == S_ADD) && add_ok && urg_q;
    n_we       = (state_q == S_ADD) && add_ok && !urg_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (action_e'(action_i))
            ACT_ADD, ACT_REMOVE: state_d = S_FIND;
            ACT_SERVE:           state_d = (active_q == '0) ? S_FIN : S_SRD;
            ACT_NONE:            state_d = S_FIN;
            default:             state_d = S_FIN;
          endcase
        end
      end
      S_FIND: begin
        if (scan_end) begin
          state_d = (act_q == ACT_ADD) ? S_ADD : S_FIN;
        end else if (scan_hit) begin
          state_d = (act_q == ACT_ADD) ? S_ADD : S_DROP;
        end
      end
      S_ADD:  state_d = S_FIN;
      S_SRD:  state_d = S_SPOP;
      S_SPOP: state_d = S_DROP;
      S_DROP: begin
        if (!(CW'(idx_q + 1'b1) < active_q)) state_d = S_FIN;
      end
      S_FIN:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < MAX_USERS; s++) begin
        uhead_q[s] <= '0;
        nhead_q[s] <= '0;
        ufill_q[s] <= '0;
        nfill_q[s] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            act_q        <= action_e'(action_i);
            uid_q        <= user_id_i;
            size_q       <= job_size_i;
            urg_q        <= is_urgent_i;
            idx_q        <= '0;
            found_q      <= 1'b0;
            requeue_q    <= 1'b0;
            slot_q       <= order_q[0];
            res_status_q <= ST_OK;
            res_user_q   <= '0;
            res_size_q   <= '0;
            res_urg_q    <= 1'b0;
            res_req_q    <= 1'b0;
            if (action_e'(action_i) == ACT_SERVE && active_q == '0) begin
              res_status_q <= ST_EMPTY;
            end
          end
        end
        S_FIND: begin
          if (scan_end) begin
            if (act_q == ACT_REMOVE) res_status_q <= ST_UNKNOWN;
          end else if (scan_hit) begin
            found_q <= 1'b1;
            slot_q  <= scan_slot;
          end else begin
            idx_q <= CW'(idx_q + 1'b1);
          end
        end
        S_ADD: begin
          if (add_tfull) begin
            res_status_q <= ST_TABLE_FULL;
          end else if (add_full) begin
            res_status_q <= ST_QUEUE_FULL;
          end else begin
            if (!found_q) begin
              uhead_q[add_slot] <= '0;
              nhead_q[add_slot] <= '0;
              ufill_q[add_slot] <= urg_q ? FW'(1) : '0;
              nfill_q[add_slot] <= urg_q ? '0 : FW'(1);
              owner_q[add_slot] <= uid_q;
              order_q[active_q[SW-1:0]] <= add_slot;
              active_q <= CW'(active_q + 1'b1);
              used_q[add_slot] <= 1'b1;
            end else if (urg_q) begin
              ufill_q[add_slot] <= FW'(add_fill + 1'b1);
            end else begin
              nfill_q[add_slot] <= FW'(add_fill + 1'b1);
            end
          end
        end
        S_SRD: ;
        S_SPOP: begin
          res_user_q <= owner_q[slot_q];
          if (ufill_q[slot_q] != '0) begin
            res_size_q <= urdata;
            res_urg_q  <= 1'b1;
            uhead_q[slot_q] <= (uhead_q[slot_q] == HW'(JOBS_PER_QUEUE - 1)) ? '0
                               : HW'(uhead_q[slot_q] + 1'b1);
            ufill_q[slot_q] <= FW'(ufill_q[slot_q] - 1'b1);
            requeue_q <= (ufill_q[slot_q] > FW'(1)) || (nfill_q[slot_q] != '0);
          end else if (nfill_q[slot_q] != '0) begin
            res_size_q <= nrdata;
            nhead_q[slot_q] <= (nhead_q[slot_q] == HW'(JOBS_PER_QUEUE - 1)) ? '0
                               : HW'(nhead_q[slot_q] + 1'b1);
            nfill_q[slot_q] <= FW'(nfill_q[slot_q] - 1'b1);
            requeue_q <= (nfill_q[slot_q] > FW'(1));
          end
        end
        S_DROP: begin
          if (CW'(idx_q + 1'b1) < active_q) begin
            order_q[idx_q[SW-1:0]] <= order_q[SW'(idx_q + 1'b1)];
            idx_q <= CW'(idx_q + 1'b1);
          end else if (requeue_q) begin
            order_q[SW'(active_q - 1'b1)] <= slot_q;
            res_req_q <= 1'b1;
          end else begin
            active_q       <= CW'(active_q - 1'b1);
            used_q[slot_q] <= 1'b0;
            uhead_q[slot_q] <= '0;
            nhead_q[slot_q] <= '0;
            ufill_q[slot_q] <= '0;
            nfill_q[slot_q] <= '0;
          end
        end
        S_FIN: begin
          if (out_load) begin
            status_q        <= res_status_q;
            served_user_q   <= res_user_q;
            served_size_q   <= res_size_q;
            served_urgent_q <= res_urg_q;
            user_requeued_q <= res_req_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign served_user_o   = served_user_q;
  assign served_size_o   = served_size_q;
  assign served_urgent_o = served_urgent_q;
  assign user_requeued_o = user_requeued_q;

endmodule
`default_nettype wire

// ----- bench/prrq_scoreboard.sv -----
// checker for the per-user priority round-robin queue: watches both channels,
// predicts each result from its own copy of the user order and job queues
// depends on prrq_pkg
`timescale 1ns / 100ps
module prrq_scoreboard
  import prrq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] user_id_i,
  input  wire logic [15:0] job_size_i,
  input  wire logic        is_urgent_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [2:0]  status_i,
  input  wire logic [15:0] served_user_i,
  input  wire logic [15:0] served_size_i,
  input  wire logic        served_urgent_i,
  input  wire logic        user_requeued_i,
  output int               errors_o,
  output int               pending_o
);

  localparam int NU = 8;
  localparam int NJ = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] user;
    logic [15:0] size;
    logic        urgent;
    logic        requeued;
  } sched_result_t;

  sched_result_t expected_q[$];

  logic [2:0]  order_m [NU];
  int          active_m;
  logic [15:0] owner_m [NU];
  logic [15:0] urg_jobs [NU][NJ];
  logic [15:0] nrm_jobs [NU][NJ];
  int          urg_head [NU];
  int          urg_fill [NU];
  int          nrm_head [NU];
  int          nrm_fill [NU];

  function automatic int locate_user(logic [15:0] uid);
    for (int i = 0; i < active_m; i++)
      if (owner_m[order_m[i]] == uid) return i;
    return -1;
  endfunction

  function automatic void clear_queues(int s);
    urg_head[s] = 0;
    urg_fill[s] = 0;
    nrm_head[s] = 0;
    nrm_fill[s] = 0;
  endfunction

  function automatic void drop_at(int pos);
    for (int i = pos; i + 1 < active_m; i++) order_m[i] = order_m[i + 1];
    if (active_m > 0) active_m--;
  endfunction

  function automatic sched_result_t schedule_step(logic [1:0] act, logic [15:0] uid,
                                                  logic [15:0] sz, logic urg);
    sched_result_t r;
    int pos;
    int s;
    bit used;
    r = '0;
    r.status = ST_OK;
    case (action_e'(act))
      ACT_ADD: begin
        pos = locate_user(uid);
        if (pos < 0 && active_m >= NU) begin
          r.status = ST_TABLE_FULL;
          return r;
        end
        if (pos < 0) begin
          s = 0;
          for (int c = NU - 1; c >= 0; c--) begin
            used = 0;
            for (int i = 0; i < active_m; i++) if (order_m[i] == c) used = 1;
            if (!used) s = c;
          end
          clear_queues(s);
        end else begin
          s = order_m[pos];
        end
        if (urg) begin
          if (urg_fill[s] >= NJ) begin
            r.status = ST_QUEUE_FULL;
            return r;
          end
          urg_jobs[s][(urg_head[s] + urg_fill[s]) % NJ] = sz;
          urg_fill[s]++;
        end else begin
          if (nrm_fill[s] >= NJ) begin
            r.status = ST_QUEUE_FULL;
            return r;
          end
          nrm_jobs[s][(nrm_head[s] + nrm_fill[s]) % NJ] = sz;
          nrm_fill[s]++;
        end
        if (pos < 0) begin
          owner_m[s] = uid;
          order_m[active_m] = s[2:0];
          active_m++;
        end
      end
      ACT_REMOVE: begin
        pos = locate_user(uid);
        if (pos < 0) r.status = ST_UNKNOWN;
        else begin
          clear_queues(order_m[pos]);
          drop_at(pos);
        end
      end
      ACT_SERVE: begin
        if (active_m == 0) begin
          r.status = ST_EMPTY;
          return r;
        end
        s = order_m[0];
        r.user = owner_m[s];
        if (urg_fill[s] > 0) begin
          r.size = urg_jobs[s][urg_head[s]];
          urg_head[s] = (urg_head[s] + 1) % NJ;
          urg_fill[s]--;
          r.urgent = 1;
        end else if (nrm_fill[s] > 0) begin
          r.size = nrm_jobs[s][nrm_head[s]];
          nrm_head[s] = (nrm_head[s] + 1) % NJ;
          nrm_fill[s]--;
        end
        drop_at(0);
        if (urg_fill[s] > 0 || nrm_fill[s] > 0) begin
          order_m[active_m] = s[2:0];
          active_m++;
          r.requeued = 1;
        end else clear_queues(s);
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t e;
    if (!rst_ni) begin
      active_m = 0;
      for (int s = 0; s < NU; s++) clear_queues(s);
      expected_q.delete();
      errors_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        expected_q.push_back(schedule_step(action_i, user_id_i, job_size_i, is_urgent_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          errors_o <= errors_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.status !== status_i || e.user !== served_user_i || e.size !== served_size_i
              || e.urgent !== served_urgent_i || e.requeued !== user_requeued_i)
            errors_o <= errors_o + 1;
          if (e.status !== status_i)
            $error("status expected %0d got %0d", e.status, status_i);
          if (e.user !== served_user_i)
            $error("served_user expected %0d got %0d", e.user, served_user_i);
          if (e.size !== served_size_i)
            $error("served_size expected %0d got %0d", e.size, served_size_i);
          if (e.urgent !== served_urgent_i)
            $error("served_urgent expected %0d got %0d", e.urgent, served_urgent_i);
          if (e.requeued !== user_requeued_i)
            $error("user_requeued expected %0d got %0d", e.requeued, user_requeued_i);
        end
      end
    end
  end

endmodule

// ----- bench/tb_per_user_priority_round_robin_queue.sv -----
// top of the scheduler bench: clock, reset, stimulus and verdict
// depends on prrq_pkg, per_user_priority_round_robin_queue and prrq_scoreboard
`timescale 1ns / 100ps
module tb_per_user_priority_round_robin_queue;
  import prrq_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [1:0]  action_i = ACT_NONE;
  logic [15:0] user_id_i = 0;
  logic [15:0] job_size_i = 0;
  logic        is_urgent_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [2:0]  status_o;
  logic [15:0] served_user_o;
  logic [15:0] served_size_o;
  logic        served_urgent_o;
  logic        user_requeued_o;
  int          errors;
  int          pending;
  bit          rx_hold = 0;
  logic [15:0] user_pool [8];

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  per_user_priority_round_robin_queue dut (.*);

  prrq_scoreboard checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .action_i, .user_id_i,
    .job_size_i, .is_urgent_i, .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .served_user_i(served_user_o), .served_size_i(served_size_o),
    .served_urgent_i(served_urgent_o), .user_requeued_i(user_requeued_o),
    .errors_o(errors), .pending_o(pending)
  );

  task automatic send_job(logic [1:0] act, logic [15:0] uid, logic [15:0] sz, logic urg,
                          int gap);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1;
    action_i    <= act;
    user_id_i   <= uid;
    job_size_i  <= sz;
    is_urgent_i <= urg;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [15:0] pick_user();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : user_pool[$urandom_range(0, 7)];
  endfunction

  always @(posedge clk_i) begin
    int wait_n;
    if (rx_hold) out_ready_i <= 0;
    else if (out_ready_i && out_valid_o) begin
      wait_n = $urandom_range(0, 4);
      out_ready_i <= (wait_n == 0);
      repeat (wait_n) @(posedge clk_i);
      if (wait_n != 0) out_ready_i <= 1;
    end else out_ready_i <= 1;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int gap;
    int roll;
    user_pool = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h1234, 16'h7FFF, 16'hAAAA,
                  16'h5555};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_job(ACT_SERVE, 0, 0, 0, 0);
    send_job(ACT_REMOVE, 16'hFFFF, 0, 0, 0);
    send_job(ACT_NONE, 16'hFFFF, 16'hFFFF, 1, 0);
    send_job(ACT_ADD, 16'h0000, 16'hFFFF, 1, 0);
    send_job(ACT_ADD, 16'h0000, 16'h0000, 0, 0);
    send_job(ACT_ADD, 16'hFFFF, 16'h5A5A, 0, 1);
    for (int u = 2; u < 8; u++) send_job(ACT_ADD, user_pool[u], 16'(u), u[0], 0);
    send_job(ACT_ADD, 16'h4242, 16'd9, 1, 0);
    send_job(ACT_SERVE, 0, 0, 0, 0);
    send_job(ACT_SERVE, 0, 0, 0, 0);
    send_job(ACT_SERVE, 0, 0, 0, 0);
    send_job(ACT_REMOVE, 16'h1234, 0, 0, 0);
    send_job(ACT_REMOVE, 16'h1234, 0, 0, 0);
    for (int k = 0; k < 17; k++) send_job(ACT_ADD, 16'h5555, 16'(k * 911), 1, 0);
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    rx_hold = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        rx_hold = 0;
      end
      for (int k = 0; k < 30; k++) send_job(ACT_SERVE, 0, 0, 0, 0);
    join
    for (int n = 0; n < 1800; n++) begin
      gap = (n % 200 < 40) ? 0 : $urandom_range(0, 4);
      roll = $urandom_range(0, 99);
      if (roll < 50)
        send_job(ACT_ADD, pick_user(), 16'($urandom), 1'($urandom), gap);
      else if (roll < 88) send_job(ACT_SERVE, pick_user(), 16'($urandom), 1'($urandom), gap);
      else if (roll < 97) send_job(ACT_REMOVE, pick_user(), 16'($urandom), 1'($urandom), gap);
      else send_job(ACT_NONE, 16'($urandom), 16'($urandom), 1'($urandom), gap);
      if (n == 900) begin
        in_valid_i <= 0;
        while (pending != 0) @(posedge clk_i);
      end
    end
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/prrq_pkg.sv
hdl/prrq_jobmem.sv
hdl/per_user_priority_round_robin_queue.sv
bench/prrq_scoreboard.sv
bench/tb_per_user_priority_round_robin_queue.sv
